// ----- hw/rtl/vrs_pkg.sv -----
// Shared types, codes and default sizes for the variable record stack.
// Used by every module of the block; depends on nothing else.
package vrs_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int WORD_DEPTH_DEF     = 1024;
    localparam int RECORD_DEPTH_DEF   = 256;
    localparam int MAX_RECORD_LEN_DEF = 64;
    localparam int VALUE_BITS_DEF     = 32;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    // Status codes on the result channel.
    localparam logic [1:0] ST_DATA         = 2'd0;
    localparam logic [1:0] ST_EMPTY_STACK  = 2'd1;
    localparam logic [1:0] ST_EMPTY_RECORD = 2'd2;
    localparam logic [1:0] ST_OVERFLOW     = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [31:0]  value;
    } in_t;

    typedef struct packed {
        logic signed [31:0]  data;
        logic [1:0]          status;
        logic                last;
    } out_t;

    // Operations that survive classification in the front.
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_COMMIT,
        OP_POP
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic signed [31:0]  value;
    } op_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POP_START,
        BK_WORD_READ,
        BK_WORD_EMIT,
        BK_MOVE_READ,
        BK_MOVE_WRITE
    } bk_state_t;

endpackage

// ----- hw/rtl/vrs_front.sv -----
// Front end of the variable record stack: accepts command transfers and
// classifies them into queue entries. Depends on vrs_pkg.
module vrs_front (
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  vrs_pkg::in_t       cmd_item,
    input  vrs_pkg::q_stat_t   q_stat,
    output logic               push,
    output vrs_pkg::op_entry_t push_entry
);

    logic keep;

    assign cmd_stall = q_stat.full;

    // Zero appends and the unused command code are dropped here.
    always_comb
    begin
        keep             = 1'b0;
        push_entry.op    = vrs_pkg::OP_POP;
        push_entry.value = cmd_item.value;
        unique case (cmd_item.command)
            vrs_pkg::CMD_APPEND:
            begin
                keep          = (cmd_item.value != 32'sd0);
                push_entry.op = vrs_pkg::OP_APPEND;
            end
            vrs_pkg::CMD_COMMIT:
            begin
                keep          = 1'b1;
                push_entry.op = vrs_pkg::OP_COMMIT;
            end
            vrs_pkg::CMD_POP:
            begin
                keep          = 1'b1;
                push_entry.op = vrs_pkg::OP_POP;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = cmd_valid && !q_stat.full && keep;

endmodule

// ----- hw/rtl/vrs_queue.sv -----
// Short command queue between the front and back of the record stack.
// Depends on vrs_pkg for the entry type and depth.
module vrs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vrs_pkg::op_entry_t push_entry,
    input  logic               pop,
    output vrs_pkg::op_entry_t head,
    output vrs_pkg::q_stat_t   q_stat
);

    localparam int QAW = (vrs_pkg::QUEUE_DEPTH > 1) ? $clog2(vrs_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(vrs_pkg::QUEUE_DEPTH + 1);

    vrs_pkg::op_entry_t entries [vrs_pkg::QUEUE_DEPTH];

    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign q_stat.full  = (count_reg == QCW'(vrs_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(vrs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(vrs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/vrs_back.sv -----
// Back end of the variable record stack: word store, record start stack,
// fill counters, pop sequencer and result register. Depends on vrs_pkg.
module vrs_back #(
    parameter int WORD_DEPTH     = vrs_pkg::WORD_DEPTH_DEF,
    parameter int RECORD_DEPTH   = vrs_pkg::RECORD_DEPTH_DEF,
    parameter int MAX_RECORD_LEN = vrs_pkg::MAX_RECORD_LEN_DEF,
    parameter int VALUE_BITS     = vrs_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vrs_pkg::q_stat_t   q_stat,
    input  vrs_pkg::op_entry_t head,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output vrs_pkg::out_t      rsp_item
);

    localparam int AW = $clog2(WORD_DEPTH);
    localparam int FW = $clog2(WORD_DEPTH + 1);
    localparam int RA = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int CW = $clog2(RECORD_DEPTH + 1);
    localparam int LW = $clog2(MAX_RECORD_LEN + 1);

    // Storage: no reset, every read is of an entry written earlier.
    logic [VALUE_BITS-1:0] word_mem [WORD_DEPTH];
    logic [FW-1:0]         start_mem [RECORD_DEPTH];

    vrs_pkg::bk_state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [LW-1:0] open_len_reg, open_len_next;
    logic [CW-1:0] count_reg, count_next;
    logic [FW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] src_reg, src_next;
    logic [FW-1:0] dst_reg, dst_next;
    logic [LW-1:0] remain_reg, remain_next;
    logic          out_valid_reg;
    vrs_pkg::out_t out_item_reg;

    logic                  wm_we;
    logic [AW-1:0]         wm_waddr;
    logic [VALUE_BITS-1:0] wm_wdata;
    logic                  wm_re;
    logic [AW-1:0]         wm_raddr;
    logic [VALUE_BITS-1:0] wm_rdata_reg;
    logic                  sm_we;
    logic [RA-1:0]         sm_waddr;
    logic                  sm_re;
    logic [RA-1:0]         sm_raddr;
    logic [FW-1:0]         sm_rdata_reg;

    logic                  out_free;
    logic                  out_load;
    vrs_pkg::out_t         out_next;
    logic signed [63:0]    in_wide;
    logic signed [VALUE_BITS-1:0] rd_s;
    logic signed [63:0]    rd_wide;
    logic [FW-1:0]         end_w;
    logic [FW-1:0]         start_w;
    logic [FW-1:0]         diff_w;
    logic [LW-1:0]         len_w;
    logic [CW-1:0]         count_dec;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign in_wide   = 64'(head.value);
    assign rd_s      = wm_rdata_reg;
    assign rd_wide   = 64'(rd_s);
    assign end_w     = fill_reg - FW'(open_len_reg);
    assign start_w   = (sm_rdata_reg > end_w) ? end_w : sm_rdata_reg;
    assign diff_w    = end_w - start_w;
    assign len_w     = (32'(diff_w) > 32'(MAX_RECORD_LEN)) ? LW'(MAX_RECORD_LEN)
                                                             : LW'(diff_w);
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        open_len_next = open_len_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        remain_next   = remain_reg;
        pop           = 1'b0;
        wm_we         = 1'b0;
        wm_waddr      = fill_reg[AW-1:0];
        wm_wdata      = in_wide[VALUE_BITS-1:0];
        wm_re         = 1'b0;
        wm_raddr      = rd_ptr_reg[AW-1:0];
        sm_we         = 1'b0;
        sm_waddr      = count_reg[RA-1:0];
        sm_re         = 1'b0;
        sm_raddr      = count_dec[RA-1:0];
        out_load      = 1'b0;
        out_next      = '{data: 32'sd0, status: vrs_pkg::ST_OVERFLOW, last: 1'b1};

        unique case (state_reg)
            vrs_pkg::BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        vrs_pkg::OP_APPEND:
                        begin
                            if (open_len_reg >= LW'(MAX_RECORD_LEN) ||
                                fill_reg >= FW'(WORD_DEPTH))
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                wm_we         = 1'b1;
                                fill_next     = fill_reg + 1'b1;
                                open_len_next = open_len_reg + 1'b1;
                            end
                        end
                        vrs_pkg::OP_COMMIT:
                        begin
                            if (count_reg >= CW'(RECORD_DEPTH))
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                sm_we         = 1'b1;
                                count_next    = count_reg + 1'b1;
                                open_len_next = '0;
                            end
                        end
                        vrs_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_next.status = vrs_pkg::ST_EMPTY_STACK;
                            end
                            else
                            begin
                                sm_re      = 1'b1;
                                count_next = count_dec;
                                state_next = vrs_pkg::BK_POP_START;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            vrs_pkg::BK_POP_START:
            begin
                if (len_w == '0)
                begin
                    // Empty record: nothing to emit and nothing to move.
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_next.status = vrs_pkg::ST_EMPTY_RECORD;
                        state_next      = vrs_pkg::BK_IDLE;
                    end
                end
                else
                begin
                    rd_ptr_next = end_w - 1'b1;
                    remain_next = len_w;
                    src_next    = end_w;
                    dst_next    = start_w;
                    fill_next   = start_w + FW'(open_len_reg);
                    state_next  = vrs_pkg::BK_WORD_READ;
                end
            end
            vrs_pkg::BK_WORD_READ:
            begin
                wm_re      = 1'b1;
                state_next = vrs_pkg::BK_WORD_EMIT;
            end
            vrs_pkg::BK_WORD_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_next.data   = rd_wide[31:0];
                    out_next.status = vrs_pkg::ST_DATA;
                    out_next.last   = (remain_reg == LW'(1));
                    rd_ptr_next     = rd_ptr_reg - 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg != LW'(1))
                    begin
                        state_next = vrs_pkg::BK_WORD_READ;
                    end
                    else if (open_len_reg != '0)
                    begin
                        remain_next = open_len_reg;
                        state_next  = vrs_pkg::BK_MOVE_READ;
                    end
                    else
                    begin
                        state_next = vrs_pkg::BK_IDLE;
                    end
                end
            end
            vrs_pkg::BK_MOVE_READ:
            begin
                wm_re      = 1'b1;
                wm_raddr   = src_reg[AW-1:0];
                state_next = vrs_pkg::BK_MOVE_WRITE;
            end
            vrs_pkg::BK_MOVE_WRITE:
            begin
                wm_we       = 1'b1;
                wm_waddr    = dst_reg[AW-1:0];
                wm_wdata    = wm_rdata_reg;
                src_next    = src_reg + 1'b1;
                dst_next    = dst_reg + 1'b1;
                remain_next = remain_reg - 1'b1;
                state_next  = (remain_reg == LW'(1)) ? vrs_pkg::BK_IDLE
                                                     : vrs_pkg::BK_MOVE_READ;
            end
            default:
            begin
                state_next = vrs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrs_pkg::BK_IDLE;
            fill_reg      <= '0;
            open_len_reg  <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            open_len_reg <= open_len_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            remain_reg   <= remain_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            word_mem[wm_waddr] <= wm_wdata;
        end
        if (wm_re)
        begin
            wm_rdata_reg <= word_mem[wm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            start_mem[sm_waddr] <= end_w;
        end
        if (sm_re)
        begin
            sm_rdata_reg <= start_mem[sm_raddr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

endmodule

// ----- hw/rtl/variable_record_stack.sv -----
// Top level of the variable record stack: front, command queue and back.
// Depends on vrs_pkg, vrs_front, vrs_queue and vrs_back.

// A LIFO stack of variable-length records of signed values. Append transfers
// (command 0, nonzero value) build an open record, a commit (command 1)
// pushes it, and a pop (command 2) returns the top record newest word first,
// with last set on the final word. A pop of an empty stack or of an empty
// record returns a single status result; appends beyond the record length
// or the word store, and commits beyond the record depth, are dropped and
// answered with an overflow result. Zero appends and command 3 produce
// nothing. Command transfers are classified in the front and queued, so
// the input keeps flowing while the back is busy, until the two-entry queue
// fills. The back handles an append, commit or empty-stack result from its idle
// state. A pop of a committed record first dequeues it and reads the record's
// start, and an empty record ends there with its status result; otherwise
// each returned word is read and then emitted, then each word of the open
// record that moves down over the freed space is read and then written back;
// this order comes from the single read port of the word store and its
// registered read data. A result stays in the output register until it is
// taken; while it is held the back waits, but word reads and moves go on.

module variable_record_stack #(
    parameter int WORD_DEPTH     = vrs_pkg::WORD_DEPTH_DEF,
    parameter int RECORD_DEPTH   = vrs_pkg::RECORD_DEPTH_DEF,
    parameter int MAX_RECORD_LEN = vrs_pkg::MAX_RECORD_LEN_DEF,
    parameter int VALUE_BITS     = vrs_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  vrs_pkg::in_t  cmd_item,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output vrs_pkg::out_t rsp_item
);

    // Queue hand-off between the front and the back.
    logic               q_push;
    logic               q_pop;
    vrs_pkg::op_entry_t q_push_entry;
    vrs_pkg::op_entry_t q_head;
    vrs_pkg::q_stat_t   q_stat;

    vrs_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    vrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    vrs_back #(
        .WORD_DEPTH     (WORD_DEPTH),
        .RECORD_DEPTH   (RECORD_DEPTH),
        .MAX_RECORD_LEN (MAX_RECORD_LEN),
        .VALUE_BITS     (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // The front must never push into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    // A full queue must hold off the input channel.
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> cmd_stall)
        else $error("input not stalled while the queue is full");

    // Status results are single-result answers with zero data.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.status != vrs_pkg::ST_DATA)
            |-> (rsp_item.last && rsp_item.data == 32'sd0))
        else $error("status result without last or with nonzero data");

    // The back only dequeues when there is something to take.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back dequeued from an empty queue");

endmodule

// ----- test/variable_record_stack_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for variable_record_stack: directed cases and random
// command streams, each result checked against a behavioural stack model.
// Depends on vrs_pkg and the variable_record_stack RTL; reads and writes no files.

module variable_record_stack_tb;

    // Sizes follow the block's default parameters, which the instance below keeps.
    localparam int WORDS   = vrs_pkg::WORD_DEPTH_DEF;
    localparam int RECORDS = vrs_pkg::RECORD_DEPTH_DEF;
    localparam int REC_LEN = vrs_pkg::MAX_RECORD_LEN_DEF;
    localparam int FILL_W  = $clog2(WORDS + 1);
    localparam int COUNT_W = $clog2(RECORDS + 1);
    localparam int OPEN_W  = $clog2(REC_LEN + 1);

    // Command 3 has no meaning; the block must swallow it silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 340;
    // The slowest legal stretch without any transfer is a pop of a full-length record
    // with a full-length open record behind it plus the longest stall; the limit below
    // is many times that.
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    vrs_pkg::in_t  cmd_item  = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    vrs_pkg::out_t rsp_item;

    variable_record_stack u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always #10 clk = ~clk;

    // Commands waiting to be driven, and results the model says are still to come.
    vrs_pkg::in_t  cmd_backlog[$];
    vrs_pkg::out_t pending_results[$];

    // Model state. The word store holds the committed words followed by the words of
    // the open record; the start stack remembers where each committed record begins.
    logic signed [31:0] word_mem [WORDS];
    logic [FILL_W-1:0]  rec_start [RECORDS];
    logic [COUNT_W-1:0] rec_count = '0;
    logic [FILL_W-1:0]  word_fill = '0;
    logic [OPEN_W-1:0]  open_len  = '0;

    int   live_items     = 0;
    int   mismatches     = 0;
    int   n_cmds         = 0;
    int   n_results      = 0;
    int   n_data         = 0;
    int   n_overflow     = 0;
    int   n_empty_stack  = 0;
    int   n_empty_record = 0;
    int   idle_cycles    = 0;

    // Handshake bookkeeping private to the driver.
    logic cmd_taken = 1'b0;
    int   cmd_gap   = 0;
    int   stall_left = 0;
    bit   cmd_quiet = 1'b0;
    bit   rsp_quiet = 1'b0;

    function automatic void add_result(logic signed [31:0] data, logic [1:0] status,
                                       logic last);
        vrs_pkg::out_t r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted command to the model and queue the results it causes.
    function automatic void stack_step(vrs_pkg::in_t item);
        logic [FILL_W-1:0] top_end;
        logic [FILL_W-1:0] base;
        logic [FILL_W-1:0] len;
        int i;
        case (item.command)
            vrs_pkg::CMD_APPEND:
            begin
                // A zero value is not a word at all and is dropped without comment.
                if (item.value != 0)
                begin
                    if (open_len >= REC_LEN || word_fill >= WORDS)
                        add_result('0, vrs_pkg::ST_OVERFLOW, 1'b1);
                    else
                    begin
                        word_mem[word_fill] = item.value;
                        word_fill++;
                        open_len++;
                    end
                end
            end
            vrs_pkg::CMD_COMMIT:
            begin
                if (rec_count >= RECORDS)
                    add_result('0, vrs_pkg::ST_OVERFLOW, 1'b1);
                else
                begin
                    rec_start[rec_count] = word_fill - open_len;
                    rec_count++;
                    open_len = '0;
                end
            end
            vrs_pkg::CMD_POP:
            begin
                if (rec_count == 0)
                    add_result('0, vrs_pkg::ST_EMPTY_STACK, 1'b1);
                else
                begin
                    rec_count--;
                    base    = rec_start[rec_count];
                    top_end = word_fill - open_len;
                    if (base > top_end)
                        base = top_end;
                    len = top_end - base;
                    if (len > REC_LEN)
                        len = REC_LEN;
                    if (len == 0)
                        add_result('0, vrs_pkg::ST_EMPTY_RECORD, 1'b1);
                    else
                    begin
                        // Newest word first; last marks the oldest one.
                        for (i = 0; i < len; i++)
                            add_result(word_mem[top_end - 1 - i], vrs_pkg::ST_DATA,
                                       i == len - 1);
                    end
                    // The open record slides down over the space the popped one freed.
                    for (i = 0; i < open_len; i++)
                        word_mem[base + i] = word_mem[top_end + i];
                    word_fill = base + open_len;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_result(vrs_pkg::out_t got);
        vrs_pkg::out_t want;
        n_results++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%t: result with none expected: data=%0d status=%0d last=%0b",
                         $time, got.data, got.status, got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got.data !== want.data || got.status !== want.status || got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display({"%t: expected data=%0d status=%0d last=%0b, ",
                          "got data=%0d status=%0d last=%0b"},
                         $time, want.data, want.status, want.last,
                         got.data, got.status, got.last);
        end
        case (want.status)
            vrs_pkg::ST_DATA:         n_data++;
            vrs_pkg::ST_OVERFLOW:     n_overflow++;
            vrs_pkg::ST_EMPTY_STACK:  n_empty_stack++;
            vrs_pkg::ST_EMPTY_RECORD: n_empty_record++;
            default:
            begin
            end
        endcase
    endfunction

    // Mostly back-to-back, sometimes a short pause and now and then a long one.
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Values for appends: mostly random, with the extremes of the field mixed in.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: v = $urandom;
        endcase
        if (v == 0)
            v = 32'h0000_0001;
        return v;
    endfunction

    // Ignored commands (zero appends and command 3) do not count towards the random total.
    function automatic void queue_cmd(logic [1:0] command, logic [31:0] value);
        vrs_pkg::in_t item;
        item.command = command;
        item.value   = value;
        cmd_backlog.push_back(item);
        if (command != CMD_UNUSED && !(command == vrs_pkg::CMD_APPEND && value == 0))
            live_items++;
    endfunction

    // Driver. Everything changes on the falling edge so that the block sees stable
    // inputs at the rising edge. A new command is presented only once the previous
    // transfer has completed, so a stalled payload never moves.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_taken)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_valid <= 1'b0;
                    cmd_gap = cmd_gap - 1;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cmd_item  <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    // Every so often switch between a gap-free run and a gappy one.
                    if ($urandom_range(0, 39) == 0)
                        cmd_quiet = !cmd_quiet;
                    cmd_gap = cmd_quiet ? 0 : next_gap();
                end
                else
                    cmd_valid <= 1'b0;
            end

            // The result side stalls independently of rsp_valid, so stalls land on
            // every phase of the back end's work, including the word moves of a pop.
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if ($urandom_range(0, 99) == 0)
                    rsp_quiet = !rsp_quiet;
                if (!rsp_quiet && $urandom_range(0, 2) == 0)
                    stall_left = next_gap();
            end
        end
    end

    // Monitor. Transfers are recognised at the rising edge from the values that held
    // just before it; the model is stepped before the result check, although a
    // command can never produce a result at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                stack_step(cmd_item);
                n_cmds++;
            end
            if (rsp_valid && !rsp_stall)
                check_result(rsp_item);
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%t: no transfer for %0d cycles, %0d commands still queued",
                         $time, IDLE_LIMIT, cmd_backlog.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int k;
        int choice;
        int roll;
        int rec_len;
        int random_items;

        // Directed cases. They start from an empty stack and leave it empty again.
        queue_cmd(vrs_pkg::CMD_POP, 32'h0000_0000);      // nothing to pop
        queue_cmd(vrs_pkg::CMD_COMMIT, 32'hFFFF_FFFF);   // commit a record with no words
        queue_cmd(vrs_pkg::CMD_POP, 32'hFFFF_FFFF);      // pop it back: empty record
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h0000_0000);   // zero append, ignored
        queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF);            // unused command, ignored
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h8000_0000);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h7FFF_FFFF);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h0000_0001);
        queue_cmd(vrs_pkg::CMD_COMMIT, 32'h0000_0000);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h5555_5555);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'hAAAA_AAAA);
        queue_cmd(vrs_pkg::CMD_COMMIT, 32'h5555_5555);
        // Leave a record open, then pop beneath it so that its words move down.
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h1234_5678);
        queue_cmd(vrs_pkg::CMD_APPEND, 32'h0000_FFFF);
        queue_cmd(vrs_pkg::CMD_POP, 32'hAAAA_AAAA);
        queue_cmd(vrs_pkg::CMD_POP, 32'h0000_0000);
        queue_cmd(vrs_pkg::CMD_COMMIT, 32'hFFFF_FFFF);
        queue_cmd(vrs_pkg::CMD_POP, 32'h7FFF_FFFF);
        queue_cmd(vrs_pkg::CMD_POP, 32'h8000_0000);
        queue_cmd(CMD_UNUSED, 32'h0000_0000);

        // Random part: mostly well-formed records followed later by pops, with open
        // records popped beneath, rare records near or over the length limit, and noise.
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    rec_len = 0;
                else if (roll < 13)
                    rec_len = $urandom_range(REC_LEN - 4, REC_LEN + 2);
                else
                    rec_len = $urandom_range(1, 6);
                for (k = 0; k < rec_len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        queue_cmd(vrs_pkg::CMD_APPEND, 32'h0000_0000);
                    queue_cmd(vrs_pkg::CMD_APPEND, pick_value());
                end
                if ($urandom_range(0, 9) != 0)
                    queue_cmd(vrs_pkg::CMD_COMMIT, $urandom);
            end
            else if (choice < 80)
            begin
                repeat ($urandom_range(1, 3))
                    queue_cmd(vrs_pkg::CMD_POP, $urandom);
            end
            else if (choice < 90)
            begin
                if ($urandom_range(0, 1))
                    queue_cmd(CMD_UNUSED, $urandom);
                else
                    queue_cmd(vrs_pkg::CMD_APPEND, 32'h0000_0000);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(vrs_pkg::CMD_APPEND, pick_value());
                queue_cmd(vrs_pkg::CMD_POP, $urandom);
            end
        end
        random_items = live_items;

        // Reset is held from the start and released on a falling edge, once only.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every command to be transferred, then for every predicted result.
        while (cmd_backlog.size() > 0 || cmd_valid)
            @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        // Allow time for any stray result that should not exist.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() > 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end

        $display({"%0d commands and %0d results transferred: %0d data words, ",
                  "%0d overflow, %0d empty-stack, %0d empty-record"},
                 n_cmds, n_results, n_data, n_overflow, n_empty_stack, n_empty_record);
        $display("Covered directed corner cases and %0d random commands; %0d mismatches",
                 random_items, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/vrs_pkg.sv
hw/rtl/vrs_front.sv
hw/rtl/vrs_queue.sv
hw/rtl/vrs_back.sv
hw/rtl/variable_record_stack.sv
test/variable_record_stack_tb.sv
